@@ design/sapp_pkg.sv @@
// shared types and constants for the servo acknowledge packet parser
`default_nettype none
package sapp_pkg;

    localparam int MAX_PAYLOAD_DEF  = 32;
    localparam int REPLAY_DEPTH_DEF = 64;
    localparam int HEADER_BYTES     = 7;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] CK_MASK   = 8'hFE;

    // register indexes on the configuration port
    localparam logic REG_CMD_LOW  = 1'b0;
    localparam logic REG_CMD_HIGH = 1'b1;

    typedef struct packed {
        logic [7:0] srv_id;
        logic [7:0] command;
        logic [5:0] data_count;
        logic [5:0] data_index;
        logic [7:0] data_byte;
        logic       is_empty;
        logic       is_last;
    } result_t;

endpackage
`default_nettype wire

@@ design/sapp_parser.sv @@
// front end: byte intake, replay buffer, header scanner and payload walk
`default_nettype none
module sapp_parser #(
    parameter int MAX_PAYLOAD  = sapp_pkg::MAX_PAYLOAD_DEF,
    parameter int REPLAY_DEPTH = sapp_pkg::REPLAY_DEPTH_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [7:0]           s_tdata,
    input  wire  [7:0]           cmd_low,
    input  wire  [7:0]           cmd_high,
    output logic                 push,
    output sapp_pkg::result_t    push_data,
    input  wire                  queue_full
);
    import sapp_pkg::*;

    localparam int AW = (REPLAY_DEPTH > 1) ? $clog2(REPLAY_DEPTH) : 1;
    localparam int FW = $clog2(REPLAY_DEPTH + 1);
    localparam int PW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [FW:0] DEPTH_W = (FW + 1)'(REPLAY_DEPTH);
    localparam logic [7:0]  HDR8    = 8'(HEADER_BYTES);
    localparam logic [7:0]  MAX_SZ  = 8'(HEADER_BYTES + MAX_PAYLOAD);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PROC,
        ST_EREAD,
        ST_EPUSH
    } state_t;

    typedef enum logic [2:0] {
        PH_HEAD1,
        PH_HEAD2,
        PH_SIZE,
        PH_ID,
        PH_CMD,
        PH_CK1,
        PH_CK2,
        PH_DATA
    } phase_t;

    state_t          state_reg, state_next;
    phase_t          phase_reg, phase_next;
    logic [7:0]      size_reg, size_next;
    logic [7:0]      servo_reg, servo_next;
    logic [7:0]      cmd_reg, cmd_next;
    logic [7:0]      ck1_reg, ck1_next;
    logic [7:0]      xacc_reg, xacc_next;
    logic [AW-1:0]   base_reg, base_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [FW-1:0]   scan_reg, scan_next;
    logic [FW-1:0]   hdr_reg, hdr_next;
    logic [5:0]      eidx_reg, eidx_next;

    logic [7:0]      rmem [REPLAY_DEPTH];
    logic [7:0]      rdata_reg;
    logic [7:0]      pmem [MAX_PAYLOAD];
    logic [7:0]      pdata_reg;

    logic            rmem_we;
    logic [AW-1:0]   rmem_waddr;
    logic            rmem_re;
    logic [AW-1:0]   rmem_raddr;
    logic            pmem_we;
    logic [PW-1:0]   pmem_waddr;

    logic [7:0]      b;
    logic [5:0]      n;
    logic [5:0]      need;
    logic [5:0]      idx;
    logic [FW-1:0]   h;
    logic [FW-1:0]   new_fill;
    logic [7:0]      x_fin;
    logic            finish;

    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [FW-1:0] pos);
        logic [FW:0] sum;
        sum = (FW + 1)'(base) + (FW + 1)'(pos);
        if (sum >= DEPTH_W)
            sum = sum - DEPTH_W;
        return sum[AW-1:0];
    endfunction

    assign b        = rdata_reg;
    assign n        = 6'(size_reg - HDR8);
    assign need     = (n == 6'd0) ? 6'd1 : n;
    assign idx      = 6'(scan_reg - hdr_reg - FW'(HEADER_BYTES));
    assign h        = (hdr_reg > fill_reg) ? fill_reg : hdr_reg;
    assign new_fill = fill_reg - h;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        size_next  = size_reg;
        servo_next = servo_reg;
        cmd_next   = cmd_reg;
        ck1_next   = ck1_reg;
        xacc_next  = xacc_reg;
        base_next  = base_reg;
        fill_next  = fill_reg;
        scan_next  = scan_reg;
        hdr_next   = hdr_reg;
        eidx_next  = eidx_reg;
        rmem_we    = 1'b0;
        rmem_waddr = wrap(base_reg, fill_reg);
        rmem_re    = 1'b0;
        rmem_raddr = wrap(base_reg, scan_reg);
        pmem_we    = 1'b0;
        pmem_waddr = idx[PW-1:0];
        finish     = 1'b0;
        x_fin      = xacc_reg;
        push       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    rmem_we    = 1'b1;
                    fill_next  = fill_reg + FW'(1);
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (scan_reg < fill_reg)
                begin
                    rmem_re    = 1'b1;
                    state_next = ST_PROC;
                end
                else
                begin
                    // drop everything ahead of the current header start
                    base_next = wrap(base_reg, h);
                    hdr_next  = '0;
                    if ((FW + 1)'(new_fill) == DEPTH_W)
                    begin
                        fill_next  = '0;
                        scan_next  = '0;
                        phase_next = PH_HEAD1;
                    end
                    else
                    begin
                        fill_next = new_fill;
                        scan_next = scan_reg - h;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_PROC:
            begin
                state_next = ST_READ;
                scan_next  = scan_reg + FW'(1);
                case (phase_reg)
                    PH_HEAD1:
                    begin
                        if (b == SYNC_BYTE)
                        begin
                            hdr_next   = scan_reg;
                            phase_next = PH_HEAD2;
                        end
                        else
                        begin
                            hdr_next = scan_reg + FW'(1);
                        end
                    end
                    PH_HEAD2:
                    begin
                        phase_next = (b == SYNC_BYTE) ? PH_SIZE : PH_HEAD1;
                    end
                    PH_SIZE:
                    begin
                        if (b > MAX_SZ)
                        begin
                            if (b == SYNC_BYTE)
                                hdr_next = hdr_reg + FW'(1);
                            else
                            begin
                                scan_next  = hdr_reg + FW'(1);
                                phase_next = PH_HEAD1;
                            end
                        end
                        else if (b < HDR8)
                        begin
                            scan_next  = hdr_reg + FW'(1);
                            phase_next = PH_HEAD1;
                        end
                        else
                        begin
                            size_next  = b;
                            xacc_next  = b;
                            phase_next = PH_ID;
                        end
                    end
                    PH_ID:
                    begin
                        servo_next = b;
                        xacc_next  = xacc_reg ^ b;
                        phase_next = PH_CMD;
                    end
                    PH_CMD:
                    begin
                        if (b >= cmd_low && b <= cmd_high)
                        begin
                            cmd_next   = b;
                            xacc_next  = xacc_reg ^ b;
                            phase_next = PH_CK1;
                        end
                        else
                        begin
                            scan_next  = hdr_reg + FW'(1);
                            phase_next = PH_HEAD1;
                        end
                    end
                    PH_CK1:
                    begin
                        ck1_next   = b;
                        phase_next = PH_CK2;
                    end
                    PH_CK2:
                    begin
                        if (b != (~ck1_reg & CK_MASK))
                        begin
                            scan_next  = hdr_reg + FW'(1);
                            phase_next = PH_HEAD1;
                        end
                        else if (size_reg == HDR8)
                            finish = 1'b1;
                        else
                            phase_next = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        pmem_we   = 1'b1;
                        xacc_next = xacc_reg ^ b;
                        x_fin     = xacc_reg ^ b;
                        if (idx + 6'd1 >= n)
                            finish = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_HEAD1;
                    end
                endcase

                if (finish)
                begin
                    phase_next = PH_HEAD1;
                    if ((x_fin & CK_MASK) == ck1_reg)
                    begin
                        hdr_next   = scan_reg + FW'(1);
                        eidx_next  = '0;
                        state_next = ST_EREAD;
                    end
                    else
                    begin
                        scan_next = hdr_reg + FW'(1);
                    end
                end
            end
            ST_EREAD:
            begin
                state_next = ST_EPUSH;
            end
            ST_EPUSH:
            begin
                if (!queue_full)
                begin
                    push      = 1'b1;
                    eidx_next = eidx_reg + 6'd1;
                    if (eidx_reg + 6'd1 == need)
                        state_next = ST_READ;
                    else
                        state_next = ST_EREAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        push_data.srv_id     = servo_reg;
        push_data.command    = cmd_reg;
        push_data.data_count = n;
        push_data.data_index = (n == 6'd0) ? 6'd0 : eidx_reg;
        push_data.data_byte  = (n == 6'd0) ? 8'd0 : pdata_reg;
        push_data.is_empty   = (n == 6'd0);
        push_data.is_last    = (eidx_reg + 6'd1 == need);
    end

    always_ff @(posedge clk)
    begin
        if (rmem_we)
            rmem[rmem_waddr] <= s_tdata;
        if (rmem_re)
            rdata_reg <= rmem[rmem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pmem_we)
            pmem[pmem_waddr] <= b;
        if (state_reg == ST_EREAD)
            pdata_reg <= pmem[eidx_reg[PW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_HEAD1;
            size_reg  <= '0;
            servo_reg <= '0;
            cmd_reg   <= '0;
            ck1_reg   <= '0;
            xacc_reg  <= '0;
            base_reg  <= '0;
            fill_reg  <= '0;
            scan_reg  <= '0;
            hdr_reg   <= '0;
            eidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            size_reg  <= size_next;
            servo_reg <= servo_next;
            cmd_reg   <= cmd_next;
            ck1_reg   <= ck1_next;
            xacc_reg  <= xacc_next;
            base_reg  <= base_next;
            fill_reg  <= fill_next;
            scan_reg  <= scan_next;
            hdr_reg   <= hdr_next;
            eidx_reg  <= eidx_next;
        end
    end

endmodule
`default_nettype wire

@@ design/sapp_queue.sv @@
// back end: short result queue whose head drives the output stream
`default_nettype none
module sapp_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  sapp_pkg::result_t    push_data,
    output logic                 full,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output sapp_pkg::result_t    head
);
    import sapp_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    result_t         entry_reg [QUEUE_DEPTH];
    logic [QW-1:0]   wr_reg, wr_next;
    logic [QW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            pop;

    assign full     = (cnt_reg == CW'(QUEUE_DEPTH));
    assign m_tvalid = (cnt_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign head     = entry_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + QW'(1) : wr_reg;
        rd_next  = pop ? rd_reg + QW'(1) : rd_reg;
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

@@ design/servo_ack_packet_parser_core.sv @@
// top level: configuration registers, parser front end and output queue
// Takes one received byte per transfer on the slave stream and gives each
// good acknowledge packet as one master-stream transfer per payload byte, or
// one transfer flagged empty. A byte is taken, then the scanner walks every
// buffered byte not yet parsed with one replay buffer read and one parse
// step each; a good packet adds one payload read and one push per result,
// and the step closes by dropping consumed bytes. A byte that exposes a bad
// header makes the scanner replay the bytes after that header's start. The
// slave side is ready only between bytes. Results sit in a four-entry queue,
// so a stalled master side holds the parser only once that queue is full.
// Command limits are to be written through the APB port only while the
// block is idle; the block itself does not enforce this.
`default_nettype none
module servo_ack_packet_parser_core #(
    parameter int MAX_PAYLOAD  = sapp_pkg::MAX_PAYLOAD_DEF,
    parameter int REPLAY_DEPTH = sapp_pkg::REPLAY_DEPTH_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  wire         m_tready,
    // srv_id[7:0], command[15:8], data_count[21:16], data_index[27:22],
    // data_byte[35:28], zero pad[39:36]
    output logic [39:0] m_tdata,
    output logic        m_tuser,   // is_empty
    output logic        m_tlast,   // is_last
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sapp_pkg::*;

    logic [7:0] cmd_low_reg;
    logic [7:0] cmd_high_reg;
    logic       wr_en;
    logic       push;
    logic       full;
    result_t    push_data;
    result_t    head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_CMD_HIGH) ? {24'd0, cmd_high_reg}
                                               : {24'd0, cmd_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_low_reg  <= 8'd65;
            cmd_high_reg <= 8'd73;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_CMD_HIGH)
                cmd_high_reg <= pwdata[7:0];
            else
                cmd_low_reg <= pwdata[7:0];
        end
    end

    sapp_parser #(
        .MAX_PAYLOAD  (MAX_PAYLOAD),
        .REPLAY_DEPTH (REPLAY_DEPTH)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cmd_low    (cmd_low_reg),
        .cmd_high   (cmd_high_reg),
        .push       (push),
        .push_data  (push_data),
        .queue_full (full)
    );

    sapp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .head      (head)
    );

    assign m_tdata = {4'd0, head.data_byte, head.data_index, head.data_count,
                      head.command, head.srv_id};
    assign m_tuser = head.is_empty;
    assign m_tlast = head.is_last;

endmodule
`default_nettype wire

@@ verif/servo_ack_packet_parser_core_test.sv @@
// testbench for the servo acknowledge packet parser: stream stimulus, apb setup, scoreboard
`default_nettype none
module servo_ack_packet_parser_core_test;
    import sapp_pkg::*;

    localparam int PAYLOAD_CAP = 32;
    localparam int REPLAY_CAP  = 64;
    localparam int RESULT_CAP  = 64;
    localparam int SETTLE      = 300;

    typedef enum int {
        P_HEAD1, P_HEAD2, P_SIZE, P_ID, P_CMD, P_CK1, P_CK2, P_DATA
    } phase_t;

    class ack_scoreboard;
        bit [7:0] cmd_low = 8'd65;
        bit [7:0] cmd_high = 8'd73;
        phase_t   phase = P_HEAD1;
        bit [7:0] frame_len, pkt_servo, pkt_cmd, pkt_ck1;
        bit [7:0] payload [PAYLOAD_CAP];
        bit [7:0] stash [REPLAY_CAP];
        int       head_pos, scan_pos, fill;
        int       step_count;
        result_t  pending [$];
        int       errors;

        function void set_reg(bit idx, bit [7:0] v);
            if (idx == REG_CMD_LOW)
                cmd_low = v;
            else
                cmd_high = v;
        endfunction

        function void emit_packet();
            int n, need;
            result_t r;
            n = frame_len - HEADER_BYTES;
            need = (n == 0) ? 1 : n;
            if (step_count + need > RESULT_CAP)
                return;
            for (int i = 0; i < need; i++)
            begin
                r.srv_id     = pkt_servo;
                r.command    = pkt_cmd;
                r.data_count = n[5:0];
                r.data_index = (n == 0) ? 6'd0 : i[5:0];
                r.data_byte  = (n == 0) ? 8'd0 : payload[i % PAYLOAD_CAP];
                r.is_empty   = (n == 0);
                r.is_last    = (i + 1 == need);
                pending.push_back(r);
                step_count++;
            end
        endfunction

        function void restart_after_header();
            scan_pos = head_pos + 1;
            phase = P_HEAD1;
        endfunction

        function void close_packet();
            bit [7:0] x;
            int n;
            n = frame_len - HEADER_BYTES;
            x = frame_len ^ pkt_servo ^ pkt_cmd;
            for (int i = 0; i < n; i++)
                x ^= payload[i % PAYLOAD_CAP];
            x &= CK_MASK;
            if (x == pkt_ck1)
            begin
                emit_packet();
                head_pos = scan_pos;
                phase = P_HEAD1;
            end
            else
                restart_after_header();
        endfunction

        function void flush_if_full();
            if (fill >= REPLAY_CAP)
            begin
                fill = 0;
                scan_pos = 0;
                head_pos = 0;
                phase = P_HEAD1;
            end
        endfunction

        // one accepted byte: works out every result it causes
        function void note_input(bit [7:0] rx);
            bit [7:0] b;
            int idx;
            step_count = 0;
            flush_if_full();
            stash[fill] = rx;
            fill++;
            while (scan_pos < fill)
            begin
                b = stash[scan_pos % REPLAY_CAP];
                scan_pos++;
                case (phase)
                    P_HEAD1:
                    begin
                        if (b == SYNC_BYTE)
                        begin
                            head_pos = scan_pos - 1;
                            phase = P_HEAD2;
                        end
                        else
                            head_pos = scan_pos;
                    end
                    P_HEAD2: phase = (b == SYNC_BYTE) ? P_SIZE : P_HEAD1;
                    P_SIZE:
                    begin
                        if (b > HEADER_BYTES + PAYLOAD_CAP)
                        begin
                            if (b == SYNC_BYTE)
                                head_pos++;
                            else
                                restart_after_header();
                        end
                        else if (b < HEADER_BYTES)
                            restart_after_header();
                        else
                        begin
                            frame_len = b;
                            phase = P_ID;
                        end
                    end
                    P_ID:
                    begin
                        pkt_servo = b;
                        phase = P_CMD;
                    end
                    P_CMD:
                    begin
                        if (b >= cmd_low && b <= cmd_high)
                        begin
                            pkt_cmd = b;
                            phase = P_CK1;
                        end
                        else
                            restart_after_header();
                    end
                    P_CK1:
                    begin
                        pkt_ck1 = b;
                        phase = P_CK2;
                    end
                    P_CK2:
                    begin
                        if (b != (~pkt_ck1 & CK_MASK))
                            restart_after_header();
                        else if (frame_len == HEADER_BYTES)
                            close_packet();
                        else
                            phase = P_DATA;
                    end
                    default:
                    begin
                        idx = scan_pos - 1 - head_pos - HEADER_BYTES;
                        payload[idx % PAYLOAD_CAP] = b;
                        if (idx + 1 >= frame_len - HEADER_BYTES)
                            close_packet();
                    end
                endcase
            end
            if (head_pos > 0)
            begin
                if (head_pos > fill)
                    head_pos = fill;
                fill -= head_pos;
                scan_pos -= head_pos;
                for (int i = 0; i < fill; i++)
                    stash[i] = stash[i + head_pos];
                head_pos = 0;
            end
            flush_if_full();
        endfunction

        function void cmp(string name, int exp_v, int act_v);
            if (exp_v != act_v)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(result_t act);
            result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer: srv_id %0d", act.srv_id);
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("srv_id", e.srv_id, act.srv_id);
            cmp("command", e.command, act.command);
            cmp("data_count", e.data_count, act.data_count);
            cmp("data_index", e.data_index, act.data_index);
            cmp("data_byte", e.data_byte, act.data_byte);
            cmp("is_empty", e.is_empty, act.is_empty);
            cmp("is_last", e.is_last, act.is_last);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [39:0] m_tdata;
    wire         m_tuser;
    wire         m_tlast;
    wire  [31:0] prdata;
    wire         pready;

    servo_ack_packet_parser_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ack_scoreboard sb = new();
    bit [7:0]      tx_bytes [$];
    int            stall_mode;
    int            cyc;
    bit            no_gaps;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stall pattern and result check
    always @(posedge clk)
    begin
        result_t act;
        cyc <= cyc + 1;
        if (cyc % 250 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (cyc % 4 == 0);
            default: m_tready <= (cyc % 40) >= 25;
        endcase
        if (rst_n && m_tvalid && m_tready)
        begin
            act.srv_id     = m_tdata[7:0];
            act.command    = m_tdata[15:8];
            act.data_count = m_tdata[21:16];
            act.data_index = m_tdata[27:22];
            act.data_byte  = m_tdata[35:28];
            act.is_empty   = m_tuser;
            act.is_last    = m_tlast;
            sb.check_result(act);
        end
    end

    initial
    begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic apb_write(bit idx, bit [7:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'($urandom), v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic set_limits(bit [7:0] lo, bit [7:0] hi);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        apb_write(REG_CMD_LOW, lo);
        apb_write(REG_CMD_HIGH, hi);
    endtask

    // sends queued bytes in bursts, with random gaps between bursts unless no_gaps is set
    task automatic send_all();
        int burst;
        burst = 0;
        while (tx_bytes.size() != 0)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                if (!no_gaps && $urandom_range(0, 2) != 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 9)) @(posedge clk);
                end
            end
            s_tvalid <= 1'b1;
            s_tdata <= tx_bytes[0];
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            sb.note_input(tx_bytes.pop_front());
            burst--;
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void add_packet(bit [7:0] id, bit [7:0] cmd, int n, int corrupt);
        bit [7:0] body [$];
        bit [7:0] ck1;
        int pos;
        ck1 = 8'(n + HEADER_BYTES) ^ id ^ cmd;
        for (int i = 0; i < n; i++)
        begin
            body.push_back(8'($urandom));
            ck1 ^= body[i];
        end
        ck1 &= CK_MASK;
        body.push_front(~ck1 & CK_MASK);
        body.push_front(ck1);
        body.push_front(cmd);
        body.push_front(id);
        body.push_front(8'(n + HEADER_BYTES));
        body.push_front(SYNC_BYTE);
        body.push_front(SYNC_BYTE);
        if (corrupt == 1)
        begin
            pos = $urandom_range(2, body.size() - 1);
            body[pos] ^= 8'(1 << $urandom_range(0, 7));
        end
        foreach (body[i])
            tx_bytes.push_back(body[i]);
    endfunction

    initial
    begin
        bit [7:0] lo, hi, c;
        int n, k;
        no_gaps = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty packet, largest payload at reset limits
        add_packet(8'h00, 8'd65, 0, 0);
        add_packet(8'hFF, 8'd73, 32, 0);
        // size 0xFF slides the header, then a valid size follows
        tx_bytes.push_back(SYNC_BYTE);
        add_packet(8'h12, 8'd66, 1, 0);
        tx_bytes = {tx_bytes, SYNC_BYTE, SYNC_BYTE, 8'd40, SYNC_BYTE, SYNC_BYTE, 8'd6};
        // unknown command, then bad checksums with a packet hidden inside
        add_packet(8'h01, 8'd64, 0, 0);
        tx_bytes = {tx_bytes, SYNC_BYTE, SYNC_BYTE, 8'd7, 8'h02, 8'd65, 8'h00, 8'h00};
        tx_bytes = {tx_bytes, SYNC_BYTE, SYNC_BYTE, 8'd9, 8'h03, 8'd65, SYNC_BYTE};
        add_packet(8'h04, 8'd67, 0, 0);
        send_all();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin lo = 8'd0; hi = 8'd255; end
                1: begin lo = 8'd255; hi = 8'd255; end
                2: begin lo = 8'd200; hi = 8'd10; end
                3: begin lo = 8'd0; hi = 8'd0; end
                4: begin lo = 8'($urandom); hi = 8'($urandom); end
                default: begin lo = 8'd65; hi = 8'd73; end
            endcase
            set_limits(lo, hi);
            no_gaps = (ph == 3);
            k = 0;
            while (k < 6)
            begin
                c = (lo <= hi) ? 8'($urandom_range(lo, hi)) : 8'($urandom);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32) : $urandom_range(0, 5);
                case ($urandom_range(0, 9))
                    0: add_packet(8'($urandom), c, n, 1);
                    1: repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom));
                    2: add_packet(8'($urandom), 8'($urandom), n, 0);
                    default: add_packet(8'($urandom), c, n, 0);
                endcase
                k += tx_bytes.size();
                send_all();
            end
        end

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

@@ servo_ack_packet_parser_core.f @@
design/sapp_pkg.sv
design/sapp_parser.sv
design/sapp_queue.sv
design/servo_ack_packet_parser_core.sv
verif/servo_ack_packet_parser_core_test.sv
